### rtl/lut_gain_curve_eval_top_defines.svh
// ----------------------------------------------------------------------------
// Gain curve evaluator: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LUT_GAIN_CURVE_EVAL_TOP_DEFINES_SVH
`define LUT_GAIN_CURVE_EVAL_TOP_DEFINES_SVH

// same-cycle implication
`define LGCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgce check failed");

// next-cycle implication
`define LGCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgce check failed");

`endif

### rtl/lgce_pkg.sv
// ----------------------------------------------------------------------------
// lgce_pkg
// Constants, codes and types of the gain curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package lgce_pkg;

   localparam int MAX_POINTS = 256;
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = NW + 1;

   localparam logic [15:0] START_VAL = 16'd655;       // 0.01 in Q16.16
   localparam logic [29:0] FRAC_LIM  = 30'h3FFF_FFFF;

   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_PRE_SCALE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INPUT_CAP    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OUTPUT_CAP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_OFFSET = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT  = 3'd5;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_SAT = 2'd1;
   localparam logic [1:0] STAT_EQX = 2'd2;

   localparam int DIV_STEPS = 30;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_S, S_SCALE, S_CHK0, S_SRD, S_SCMP, S_RD1, S_SEG,
      S_DIV, S_FRAC, S_MUL_I, S_INTERP, S_OCAP, S_MUL_G, S_GAIN, S_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/lut_gain_curve_eval_top.sv
// ----------------------------------------------------------------------------
// lut_gain_curve_eval_top
// Piecewise-linear gain curve over a table of up to 256 Q16.16 points.
// ----------------------------------------------------------------------------
// A load beat (kind 0) writes one (x, y) point into the table. An evaluate
// beat (kind 1) offsets and scales the speed, binary searches the table,
// interpolates the segment and applies caps and the sensitivity, returning
// one rsp beat of gain and status. One item is in work at a time; an
// evaluation takes up to nine search steps (synchronous read, then compare),
// bit-serial division for the segment fraction and three passes through one
// shared registered multiplier. Below the first point or with fewer than two
// points the search and division are skipped; equal or far-off neighbours
// skip the division. A stalled rsp beat adds its stall. A finished result
// waits in the rsp register while the next req beat is taken. The tables
// have no reset; point_count tells how many entries are in use. The user
// must write configuration only while idle; the block itself does not
// enforce it.
`default_nettype none

module lut_gain_curve_eval_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_kind,
   input  wire logic [7:0]                     req_point_index,
   input  wire logic [31:0]                    req_point_x,
   input  wire logic signed [31:0]             req_point_y,
   input  wire logic [31:0]                    req_speed,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic signed [31:0]             rsp_gain,
   output      logic [1:0]                     rsp_status,
   input  wire logic                           csr_write,
   input  wire logic [lgce_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata
);
   import lgce_pkg::*;

   // configuration
   logic [31:0] pre_scale_ff, input_cap_ff, sens_ff, offset_ff;
   logic [30:0] output_cap_ff;
   logic [8:0]  pcount_ff;

   state_type state_ff, state_in;

   // table memories
   logic [31:0]        x_mem [MAX_POINTS];
   logic signed [31:0] y_mem [MAX_POINTS];
   logic [31:0]        x_rd_ff;
   logic signed [31:0] y_rd_ff;
   logic [AW-1:0]      rd_addr;

   // shared multiplier
   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [66:0] mul_p_ff;

   // datapath
   logic [32:0]        sx_ff;
   logic [31:0]        xq_ff;
   logic [NW-1:0]      n_ff;
   logic signed [CW-1:0] lo_ff, hi_ff;
   logic [AW-1:0]      best_ff, mid_ff, pos_ff;
   logic [31:0]        x0_ff;
   logic signed [31:0] y0_ff, y1_ff;
   logic [32:0]        dmag_ff, rem_ff;
   logic [29:0]        nsh_ff, q_ff;
   logic               neg_ff;
   logic [4:0]         cnt_ff;
   logic signed [30:0] frac_ff;
   logic               sat_ff, eqx_ff;
   logic signed [48:0] val_ff;
   logic signed [31:0] val32_ff, gain_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_gain_ff;
   logic [1:0]         rsp_status_ff;

   logic req_acc, rsp_free;
   assign req_acc  = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // front end: speed - offset + 0.01, non-positive results replaced by 0.01
   logic signed [33:0] xs;
   logic [32:0]        sx_in;
   assign xs    = $signed({2'b00, req_speed}) - $signed({2'b00, offset_ff})
                + $signed({18'd0, START_VAL});
   assign sx_in = (xs[33] || xs == '0) ? {17'd0, START_VAL} : xs[32:0];

   // table size in use
   logic [NW-1:0] n_cur;
   assign n_cur = (32'(pcount_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pcount_ff);

   // scaled speed from the multiplier
   logic        scl_over;
   logic [31:0] scl, scl_cap;
   assign scl_over = |mul_p_ff[66:48];
   assign scl      = scl_over ? 32'hFFFF_FFFF : mul_p_ff[47:16];
   assign scl_cap  = (input_cap_ff != '0 && scl > input_cap_ff) ? input_cap_ff : scl;

   // search step
   logic               srch_go;
   logic signed [CW-1:0] sum;
   logic [AW-1:0]      mid_cur, pos_cur;
   assign srch_go = lo_ff <= hi_ff;
   assign sum     = lo_ff + hi_ff;
   assign mid_cur = AW'(sum >>> 1);
   assign pos_cur = (best_ff == '0) ? '0 : best_ff - AW'(1);

   // segment set-up
   logic signed [32:0] den, dx;
   logic [32:0]        dmag, nmag;
   logic               ovf;
   assign den  = $signed({1'b0, x_rd_ff}) - $signed({1'b0, x0_ff});
   assign dx   = $signed({1'b0, xq_ff}) - $signed({1'b0, x0_ff});
   assign dmag = den[32] ? 33'(-den) : 33'(den);
   assign nmag = dx[32] ? 33'(-dx) : 33'(dx);
   assign ovf  = {14'd0, nmag} >= {dmag, 14'd0};

   // restoring division step
   logic [32:0] r2;
   logic        ge;
   assign r2 = {rem_ff[31:0], nsh_ff[29]};
   assign ge = r2 >= dmag_ff;

   // caps and clipping
   logic signed [48:0] v_cap;
   logic               v_hi, v_lo;
   assign v_cap = (output_cap_ff != '0 && val_ff > $signed({18'd0, output_cap_ff}))
                ? $signed({18'd0, output_cap_ff}) : val_ff;
   assign v_hi  = v_cap > $signed(49'sd2147483647);
   assign v_lo  = v_cap < -$signed(49'sd2147483648);

   logic signed [50:0] g_full;
   logic               g_hi, g_lo;
   assign g_full = mul_p_ff[66:16];
   assign g_hi   = g_full > $signed(51'sd2147483647);
   assign g_lo   = g_full < -$signed(51'sd2147483648);

   logic signed [32:0] dy;
   assign dy = $signed({y1_ff[31], y1_ff}) - $signed({y0_ff[31], y0_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_acc && req_kind == KIND_EVAL) state_in = S_MUL_S;
         S_MUL_S:  state_in = S_SCALE;
         S_SCALE:  state_in = S_CHK0;
         S_CHK0: begin
            if (n_ff == '0 || n_ff == NW'(1) || xq_ff < x_rd_ff) state_in = S_OCAP;
            else state_in = S_SRD;
         end
         S_SRD:    state_in = srch_go ? S_SCMP : S_RD1;
         S_SCMP:   state_in = S_SRD;
         S_RD1:    state_in = S_SEG;
         S_SEG:    state_in = (den == '0 || ovf) ? S_MUL_I : S_DIV;
         S_DIV:    if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = S_FRAC;
         S_FRAC:   state_in = S_MUL_I;
         S_MUL_I:  state_in = S_INTERP;
         S_INTERP: state_in = S_OCAP;
         S_OCAP:   state_in = S_MUL_G;
         S_MUL_G:  state_in = S_GAIN;
         S_GAIN:   state_in = S_DONE;
         S_DONE:   if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control outputs: handshake, read address, multiplier operands
   always_comb begin
      req_stall = 1'b1;
      rd_addr   = '0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_IDLE:  req_stall = 1'b0;
         S_MUL_S: begin
            mul_a = $signed({1'b0, sx_ff});
            mul_b = $signed({1'b0, pre_scale_ff});
         end
         S_SRD:   rd_addr = srch_go ? mid_cur : pos_cur;
         S_RD1:   rd_addr = pos_ff + AW'(1);
         S_MUL_I: begin
            mul_a = 34'(dy);
            mul_b = 33'(frac_ff);
         end
         S_MUL_G: begin
            mul_a = 34'(val32_ff);
            mul_b = $signed({1'b0, sens_ff});
         end
         default: ;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_scale_ff  <= 32'd65536;
         input_cap_ff  <= '0;
         output_cap_ff <= '0;
         sens_ff       <= 32'd65536;
         offset_ff     <= '0;
         pcount_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PRE_SCALE:    pre_scale_ff  <= csr_wdata;
            REG_INPUT_CAP:    input_cap_ff  <= csr_wdata;
            REG_OUTPUT_CAP:   output_cap_ff <= csr_wdata[30:0];
            REG_SENSITIVITY:  sens_ff       <= csr_wdata;
            REG_SPEED_OFFSET: offset_ff     <= csr_wdata;
            REG_POINT_COUNT:  pcount_ff     <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // tables: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (req_acc && req_kind == KIND_LOAD && 32'(req_point_index) < MAX_POINTS) begin
         x_mem[AW'(req_point_index)] <= req_point_x;
         y_mem[AW'(req_point_index)] <= req_point_y;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            sx_ff  <= sx_in;
            sat_ff <= 1'b0;
            eqx_ff <= 1'b0;
         end
         S_SCALE: begin
            xq_ff <= scl_cap;
            n_ff  <= n_cur;
            if (scl_over) sat_ff <= 1'b1;
         end
         S_CHK0: begin
            if (n_ff == '0) val_ff <= '0;
            else            val_ff <= 49'(y_rd_ff);
            lo_ff   <= '0;
            hi_ff   <= CW'(n_ff) - CW'(1);
            best_ff <= AW'(n_ff - NW'(1));
         end
         S_SRD: begin
            mid_ff <= mid_cur;
            pos_ff <= pos_cur;
         end
         S_SCMP: begin
            if (xq_ff > x_rd_ff) begin
               lo_ff <= CW'(mid_ff) + CW'(1);
            end else begin
               best_ff <= mid_ff;
               hi_ff   <= CW'(mid_ff) - CW'(1);
            end
         end
         S_RD1: begin
            x0_ff <= x_rd_ff;
            y0_ff <= y_rd_ff;
         end
         S_SEG: begin
            y1_ff   <= y_rd_ff;
            dmag_ff <= dmag;
            rem_ff  <= nmag >> 14;
            nsh_ff  <= {nmag[13:0], 16'd0};
            q_ff    <= '0;
            cnt_ff  <= '0;
            neg_ff  <= dx[32] ^ den[32];
            if (den == '0) begin
               eqx_ff  <= 1'b1;
               frac_ff <= '0;
            end else if (ovf) begin
               sat_ff  <= 1'b1;
               frac_ff <= (dx[32] ^ den[32]) ? -$signed({1'b0, FRAC_LIM})
                                             : $signed({1'b0, FRAC_LIM});
            end
         end
         S_DIV: begin
            rem_ff <= ge ? r2 - dmag_ff : r2;
            q_ff   <= {q_ff[28:0], ge};
            nsh_ff <= {nsh_ff[28:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
         end
         S_FRAC: frac_ff <= neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
         S_INTERP: val_ff <= 49'(y0_ff) + mul_p_ff[64:16];
         S_OCAP: begin
            if (v_hi)      val32_ff <= 32'sh7FFF_FFFF;
            else if (v_lo) val32_ff <= 32'sh8000_0000;
            else           val32_ff <= v_cap[31:0];
            if (v_hi || v_lo) sat_ff <= 1'b1;
         end
         S_GAIN: begin
            if (g_hi)      gain_ff <= 32'sh7FFF_FFFF;
            else if (g_lo) gain_ff <= 32'sh8000_0000;
            else           gain_ff <= g_full[31:0];
            if (g_hi || g_lo) sat_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_gain_ff   <= gain_ff;
         rsp_status_ff <= sat_ff ? STAT_SAT : (eqx_ff ? STAT_EQX : STAT_OK);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_gain   = rsp_gain_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/lgce_checker.sv
// ----------------------------------------------------------------------------
// lgce_checker
// Port-level checks on the gain curve evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lut_gain_curve_eval_top_defines.svh"

module lgce_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           req_kind,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic signed [31:0]             rsp_gain,
   input wire logic [1:0]                     rsp_status
);
   import lgce_pkg::*;

   // held rsp beat keeps its payload
   `LGCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_gain) && $stable(rsp_status))
   // after a load the block takes a request again in the next cycle
   `LGCE_ASSERT_NEXT(a_load_one, clock, reset, req_valid && !req_stall && req_kind == KIND_LOAD, !req_stall)
   // an evaluation keeps the block busy
   `LGCE_ASSERT_NEXT(a_eval_busy, clock, reset, req_valid && !req_stall && req_kind == KIND_EVAL, req_stall)
   // status code three is never produced
   `LGCE_ASSERT_NOW(a_status, clock, reset, rsp_valid, rsp_status != 2'd3)
   // no result straight out of reset
   `LGCE_ASSERT_NEXT(a_rst, clock, 1'b0, reset, !rsp_valid)

endmodule

bind lut_gain_curve_eval_top lgce_checker u_lgce_checker (.*);

`default_nettype wire
